### src/skin_pixel_classifier_top_macros.svh
// Assertion helpers, sampled on clk, off during reset.
`ifndef SKIN_PIXEL_CLASSIFIER_TOP_MACROS_SVH
`define SKIN_PIXEL_CLASSIFIER_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = 4;
  localparam int PIPE_DEPTH      = 3 + DIV_STAGES + 1;

  localparam int HUE_W = 15;
  localparam int NUM_W = 23;

  localparam logic [HUE_W-1:0] HUE_BELOW_RST = 15'd2259;
  localparam logic [HUE_W-1:0] HUE_ABOVE_RST = 15'd20781;

  localparam logic REG_HUE_BELOW = 1'b0;
  localparam logic REG_HUE_ABOVE = 1'b1;

  // luma, Q.14
  localparam logic [21:0] Y_R   = 22'd4899;
  localparam logic [21:0] Y_G   = 22'd9617;
  localparam logic [21:0] Y_B   = 22'd1868;
  localparam logic [21:0] Y_RND = 22'd8192;

  // chroma, Q.14, offset 128 plus rounding
  localparam logic signed [23:0] CR_K   = 24'sd11682;
  localparam logic signed [23:0] CB_K   = 24'sd9241;
  localparam logic signed [23:0] C_OFS  = 24'sd2105344;

  // hue sector offsets, 1/64 degree
  localparam logic signed [23:0] HUE_SEXT = 24'sd3840;
  localparam logic signed [23:0] HUE_OFS_G = 24'sd7680;
  localparam logic signed [23:0] HUE_OFS_B = 24'sd15360;
  localparam logic signed [23:0] HUE_FULL  = 24'sd23040;

  // rgb rule thresholds
  localparam logic [7:0] R1_MIN     = 8'd95;
  localparam logic [7:0] G1_MIN     = 8'd40;
  localparam logic [7:0] B1_MIN     = 8'd20;
  localparam logic [7:0] SPREAD_MIN = 8'd15;
  localparam logic [7:0] R2_MIN     = 8'd220;
  localparam logic [7:0] G2_MIN     = 8'd210;
  localparam logic [7:0] B2_MIN     = 8'd170;

  // Cr/Cb lines, Q.12
  localparam logic signed [24:0] LN1_A = 25'sd6497;
  localparam logic signed [24:0] LN1_C = 25'sd81920;
  localparam logic signed [24:0] LN2_A = 25'sd1412;
  localparam logic signed [24:0] LN2_C = 25'sd312143;
  localparam logic signed [24:0] LN3_A = -25'sd18699;
  localparam logic signed [24:0] LN3_C = 25'sd960779;
  localparam logic signed [24:0] LN4_A = -25'sd4710;
  localparam logic signed [24:0] LN4_C = 25'sd1235968;
  localparam logic signed [24:0] LN5_A = -25'sd9362;
  localparam logic signed [24:0] LN5_C = 25'sd1772954;

  typedef enum logic [1:0] {
    HUE_R = 2'b00,
    HUE_G = 2'b01,
    HUE_B = 2'b10
  } hsel_t;

  typedef struct packed {
    logic [7:0]        r;
    logic [7:0]        b;
    logic [7:0]        y;
    logic              rgb_ok;
    logic [7:0]        d;
    logic signed [8:0] t;
    hsel_t             sel;
  } color_t;

  typedef struct packed {
    logic [7:0]       cr;
    logic [7:0]       cb;
    logic [NUM_W-1:0] n;
    logic [7:0]       d;
    logic             rgb_ok;
  } chroma_t;

  // st = {remainder, numerator bits left / quotient bits so far}
  typedef struct packed {
    logic [NUM_W-1:0] st;
    logic [7:0]       d;
    logic             ok;
  } div_t;

  function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] st,
                                                input logic [7:0] d);
    logic [8:0] t9;
    logic       q;
    logic [7:0] rem;
    t9  = {st[NUM_W-1:HUE_W], st[HUE_W-1]};
    q   = (t9 >= {1'b0, d});
    rem = q ? 8'(t9 - {1'b0, d}) : t9[7:0];
    return {rem, st[HUE_W-2:0], q};
  endfunction

  function automatic logic [NUM_W-1:0] div_steps(input logic [NUM_W-1:0] st,
                                                 input logic [7:0] d);
    logic [NUM_W-1:0] s;
    s = st;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      s = div_step(s, d);
    end
    return s;
  endfunction

endpackage

### src/spc_color.sv
`timescale 1ns / 1ps

module spc_color (
  input  logic            clk,
  input  logic            load,
  input  logic [7:0]      blue,
  input  logic [7:0]      green,
  input  logic [7:0]      red,
  output spc_pkg::color_t stage_o
);
  import spc_pkg::*;

  color_t      stage_r;
  color_t      stage_nxt;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  drg;
  logic [21:0] ysum;
  logic        rule1;
  logic        rule2;

  always_comb begin
    mx = (red > green) ? red : green;
    mn = (red < green) ? red : green;
    if (blue > mx) mx = blue;
    if (blue < mn) mn = blue;
    drg = (red >= green) ? 8'(red - green) : 8'(green - red);

    rule1 = (red > R1_MIN) && (green > G1_MIN) && (blue > B1_MIN) &&
            (8'(mx - mn) > SPREAD_MIN) && (drg > SPREAD_MIN) &&
            (red > green) && (red > blue);
    rule2 = (red > R2_MIN) && (green > G2_MIN) && (blue > B2_MIN) &&
            (drg <= SPREAD_MIN) && (red > blue) && (green > blue);

    ysum = Y_R * 22'(red) + Y_G * 22'(green) + Y_B * 22'(blue) + Y_RND;

    stage_nxt.r      = red;
    stage_nxt.b      = blue;
    stage_nxt.y      = ysum[21:14];
    stage_nxt.rgb_ok = rule1 || rule2;
    stage_nxt.d      = 8'(mx - mn);
    if (mx == red) begin
      stage_nxt.sel = HUE_R;
    end else if (mx == green) begin
      stage_nxt.sel = HUE_G;
    end else begin
      stage_nxt.sel = HUE_B;
    end
    case (stage_nxt.sel)
      HUE_R:   stage_nxt.t = signed'({1'b0, green} - {1'b0, blue});
      HUE_G:   stage_nxt.t = signed'({1'b0, blue} - {1'b0, red});
      HUE_B:   stage_nxt.t = signed'({1'b0, red} - {1'b0, green});
      default: stage_nxt.t = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### src/spc_chroma.sv
`timescale 1ns / 1ps

module spc_chroma (
  input  logic             clk,
  input  logic             load,
  input  spc_pkg::color_t  stage_i,
  output spc_pkg::chroma_t stage_o
);
  import spc_pkg::*;

  chroma_t            stage_r;
  chroma_t            stage_nxt;
  logic signed [8:0]  rmy;
  logic signed [8:0]  bmy;
  logic signed [23:0] crv;
  logic signed [23:0] cbv;
  logic signed [23:0] tmul;
  logic signed [23:0] kd;
  logic signed [23:0] dx;
  logic signed [23:0] num;

  function automatic logic [7:0] sat8(input logic signed [23:0] v);
    logic [9:0] sh;
    sh = v[23:14];
    if (v < 0) begin
      return 8'd0;
    end else if (sh > 10'd255) begin
      return 8'd255;
    end else begin
      return sh[7:0];
    end
  endfunction

  always_comb begin
    rmy  = signed'({1'b0, stage_i.r} - {1'b0, stage_i.y});
    bmy  = signed'({1'b0, stage_i.b} - {1'b0, stage_i.y});
    crv  = 24'(rmy) * CR_K + C_OFS;
    cbv  = 24'(bmy) * CB_K + C_OFS;

    dx   = signed'({16'b0, stage_i.d});
    tmul = 24'(stage_i.t) * HUE_SEXT;
    case (stage_i.sel)
      HUE_R:   kd = stage_i.t[8] ? dx * HUE_FULL : 24'sd0;
      HUE_G:   kd = dx * HUE_OFS_G;
      HUE_B:   kd = dx * HUE_OFS_B;
      default: kd = 24'sd0;
    endcase
    num = tmul + kd;

    stage_nxt.cr     = sat8(crv);
    stage_nxt.cb     = sat8(cbv);
    stage_nxt.n      = num[NUM_W-1:0] + NUM_W'(stage_i.d[7:1]);
    stage_nxt.d      = stage_i.d;
    stage_nxt.rgb_ok = stage_i.rgb_ok;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### src/spc_line.sv
`timescale 1ns / 1ps

module spc_line (
  input  logic             clk,
  input  logic             load,
  input  spc_pkg::chroma_t stage_i,
  output spc_pkg::div_t    stage_o
);
  import spc_pkg::*;

  div_t               stage_r;
  div_t               stage_nxt;
  logic signed [24:0] lhs;
  logic signed [24:0] cbx;
  logic               chroma_ok;

  always_comb begin
    lhs = signed'({5'b0, stage_i.cr, 12'b0});
    cbx = signed'({17'b0, stage_i.cb});
    chroma_ok = (lhs <= LN1_A * cbx + LN1_C) &&
                (lhs >= LN2_A * cbx + LN2_C) &&
                (lhs >= LN3_A * cbx + LN3_C) &&
                (lhs <= LN4_A * cbx + LN4_C) &&
                (lhs <= LN5_A * cbx + LN5_C);

    // top numerator bits are already below d, so they seed the remainder
    stage_nxt.st = div_steps(stage_i.n, stage_i.d);
    stage_nxt.d  = stage_i.d;
    stage_nxt.ok = stage_i.rgb_ok && chroma_ok;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### src/spc_div.sv
`timescale 1ns / 1ps

module spc_div (
  input  logic          clk,
  input  logic          load,
  input  spc_pkg::div_t stage_i,
  output spc_pkg::div_t stage_o
);
  import spc_pkg::*;

  div_t stage_r;
  div_t stage_nxt;

  always_comb begin
    stage_nxt    = stage_i;
    stage_nxt.st = div_steps(stage_i.st, stage_i.d);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### src/skin_pixel_classifier_top.sv
// Skin pixel classifier.
// Input channel: in_valid/in_stall with in_blue, in_green, in_red, one pixel
// per transfer. Result channel: out_valid/out_stall with out_skin_flag, one
// result per pixel, in order.
// Configuration: APB-style write/read of hue_below_limit at 0x0 and
// hue_above_limit at 0x4 (15 bits each); pready is tied high.
// Throughput: one pixel per cycle while out_stall is low. Each pixel
// passes through the 8-stage pipeline (color, chroma, line tests plus
// three divider steps, four stages of three hue divider steps, output
// register); the hue quotient is resolved three bits per stage.
// Reset (synchronous, rst_n low): all stages empty, limits return to
// 2259 and 20781.
// When the receiver stalls, the result holds on the output; upstream stages
// keep filling empty slots, and in_stall rises only once every stage holds
// a pixel.
`timescale 1ns / 1ps
`include "skin_pixel_classifier_top_macros.svh"

module skin_pixel_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_skin_flag,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import spc_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [PIPE_DEPTH:0]   rdy;
  logic [HUE_W-1:0]      hue_below_r;
  logic [HUE_W-1:0]      hue_above_r;
  logic                  cfg_wr;
  logic [HUE_W-1:0]      hue;
  logic                  flag_r;
  logic                  flag_nxt;

  color_t  color_s;
  chroma_t chroma_s;
  div_t    div_s [DIV_STAGES+1];

  // stage handshake: a stage loads when empty or when its contents move on
  always_comb begin
    rdy[PIPE_DEPTH] = !out_stall;
    for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[PIPE_DEPTH-1];

  spc_color u_color (
    .clk     (clk),
    .load    (rdy[0]),
    .blue    (in_blue),
    .green   (in_green),
    .red     (in_red),
    .stage_o (color_s)
  );

  spc_chroma u_chroma (
    .clk     (clk),
    .load    (rdy[1]),
    .stage_i (color_s),
    .stage_o (chroma_s)
  );

  spc_line u_line (
    .clk     (clk),
    .load    (rdy[2]),
    .stage_i (chroma_s),
    .stage_o (div_s[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    spc_div u_div (
      .clk     (clk),
      .load    (rdy[3+k]),
      .stage_i (div_s[k]),
      .stage_o (div_s[k+1])
    );
  end

  // grey pixel: d is zero, hue is zero
  always_comb begin
    hue      = (div_s[DIV_STAGES].d == 8'd0) ? '0 : div_s[DIV_STAGES].st[HUE_W-1:0];
    flag_nxt = div_s[DIV_STAGES].ok && ((hue < hue_below_r) || (hue > hue_above_r));
  end

  always_ff @(posedge clk) begin
    if (rdy[PIPE_DEPTH-1]) begin
      flag_r <= flag_nxt;
    end
  end

  assign out_skin_flag = flag_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_below_r <= HUE_BELOW_RST;
      hue_above_r <= HUE_ABOVE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_HUE_BELOW: hue_below_r <= cfg_pwdata[HUE_W-1:0];
        REG_HUE_ABOVE: hue_above_r <= cfg_pwdata[HUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_HUE_BELOW: cfg_prdata = {17'b0, hue_below_r};
      REG_HUE_ABOVE: cfg_prdata = {17'b0, hue_above_r};
      default:       cfg_prdata = '0;
    endcase
  end

  `SPC_ASSERT_NEXT(a_cfg_below, cfg_wr && (cfg_paddr[2] == REG_HUE_BELOW), hue_below_r == $past(cfg_pwdata[HUE_W-1:0]), "hue_below_limit write lost")
  `SPC_ASSERT_NEXT(a_cfg_above, cfg_wr && (cfg_paddr[2] == REG_HUE_ABOVE), hue_above_r == $past(cfg_pwdata[HUE_W-1:0]), "hue_above_limit write lost")
  `SPC_ASSERT_NEXT(a_pipe_adv, vld_r[PIPE_DEPTH-2] && !out_stall, out_valid, "pixel dropped before output stage")
  `SPC_ASSERT_NOW(a_hue_range, vld_r[PIPE_DEPTH-2] && (div_s[DIV_STAGES].d != 8'd0), div_s[DIV_STAGES].st[HUE_W-1:0] <= 15'd23040, "hue quotient out of range")

endmodule

### tb/tb_skin_pixel_classifier_top.sv
`timescale 1ns / 1ps

module tb_skin_pixel_classifier_top;
  import spc_pkg::*;

  localparam logic [2:0] ADDR_HUE_BELOW = {REG_HUE_BELOW, 2'b00};
  localparam logic [2:0] ADDR_HUE_ABOVE = {REG_HUE_ABOVE, 2'b00};
  localparam int HUE_MAX = 23040;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_blue = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_red = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_skin_flag;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  skin_pixel_classifier_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_blue(in_blue),
    .in_green(in_green),
    .in_red(in_red),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_skin_flag(out_skin_flag),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_t pixel_queue[$];
  bit     skin_expected[$];
  int     pixels_queued = 0;
  int     pixels_sent = 0;
  int     error_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_left = 0;
  int     hue_lo_limit = int'(HUE_BELOW_RST);
  int     hue_hi_limit = int'(HUE_ABOVE_RST);

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int sat_chroma(input int v);
    int s;
    if (v < 0) return 0;
    s = v >>> 14;
    return (s > 255) ? 255 : s;
  endfunction

  function automatic bit classify_skin(input int r, input int g, input int b);
    int  mx, mn, d, drg, y, cr, cb, lhs, num, hue;
    bit  rgb_ok, chroma_ok, hue_ok;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    d = mx - mn;
    drg = (r > g) ? r - g : g - r;
    rgb_ok = (r > 95 && g > 40 && b > 20 && d > 15 && drg > 15 && r > g && r > b) ||
             (r > 220 && g > 210 && b > 170 && drg <= 15 && r > b && g > b);

    y = (4899 * r + 9617 * g + 1868 * b + 8192) >>> 14;
    cr = sat_chroma((r - y) * 11682 + (128 << 14) + 8192);
    cb = sat_chroma((b - y) * 9241 + (128 << 14) + 8192);
    lhs = cr * 4096;
    chroma_ok = lhs <= 6497 * cb + 81920 &&
                lhs >= 1412 * cb + 312143 &&
                lhs >= -18699 * cb + 960779 &&
                lhs <= -4710 * cb + 1235968 &&
                lhs <= -9362 * cb + 1772954;

    if (d == 0) begin
      hue = 0;
    end else begin
      if (mx == r) num = (g - b) * 3840;
      else if (mx == g) num = (b - r) * 3840 + 7680 * d;
      else num = (r - g) * 3840 + 15360 * d;
      if (num < 0) num += HUE_MAX * d;
      hue = (num + d / 2) / d;
    end
    hue_ok = hue < hue_lo_limit || hue > hue_hi_limit;
    return rgb_ok && chroma_ok && hue_ok;
  endfunction

  // driver
  always @(posedge clk) begin
    pixel_t nxt;
    bit     fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        skin_expected.insert(skin_expected.size(), classify_skin(in_red, in_green, in_blue));
        pixels_sent++;
      end
      if (in_valid && !fire) begin
        // stalled transfer holds
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_queue.size() != 0 && send_idle_pct != 0 &&
                   $urandom_range(99, 0) < send_idle_pct) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(10, 0);
      end else if (pixel_queue.size() != 0) begin
        nxt = pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_blue  <= nxt.blue;
        in_green <= nxt.green;
        in_red   <= nxt.red;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else if (recv_gap != 0) begin
      out_stall <= 1'b1;
      recv_gap  <= recv_gap - 1;
    end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
      out_stall <= 1'b1;
      recv_gap  <= $urandom_range(10, 0);
    end else begin
      out_stall <= (hold_left != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (skin_expected.size() == 0) begin
        report_mismatch($sformatf("result %0b with no pixel pending", out_skin_flag));
      end else begin
        want = skin_expected.pop_front();
        if (out_skin_flag !== want)
          report_mismatch($sformatf("skin_flag got %b want %b", out_skin_flag, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_pixel(input int r, input int g, input int b);
    pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    pixel_queue.insert(pixel_queue.size(), p);
    pixels_queued++;
  endtask

  task automatic add_random_pixel();
    int r, g, b, sel;
    sel = $urandom_range(5, 0);
    case (sel)
      0, 1: begin
        r = $urandom_range(255, 0);
        g = $urandom_range(255, 0);
        b = $urandom_range(255, 0);
      end
      2, 3: begin
        r = $urandom_range(255, 96);
        g = $urandom_range(r - 16, 41);
        b = $urandom_range(r - 1, 21);
      end
      4: begin
        r = $urandom_range(255, 221);
        g = $urandom_range(255, 211);
        b = $urandom_range(((r < g) ? r : g) - 1, 171);
      end
      default: begin
        r = $urandom_range(255, 0);
        g = r;
        b = r;
        case ($urandom_range(3, 0))
          0: r = $urandom_range(255, 0);
          1: g = $urandom_range(255, 0);
          2: b = $urandom_range(255, 0);
          default: ;
        endcase
      end
    endcase
    add_pixel(r, g, b);
  endtask

  task automatic write_reg(input logic [2:0] addr, input int limit);
    logic [31:0] data;
    data = {$urandom_range(1, 0) ? 17'($urandom) : 17'd0, limit[14:0]};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_HUE_BELOW) hue_lo_limit = int'(data[14:0]);
    else if (addr == ADDR_HUE_ABOVE) hue_hi_limit = int'(data[14:0]);
  endtask

  task automatic set_limits(input int lo, input int hi);
    write_reg(ADDR_HUE_BELOW, lo);
    write_reg(ADDR_HUE_ABOVE, hi);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (!(pixels_sent == pixels_queued && skin_expected.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) add_random_pixel();
    drain();
  endtask

  task automatic pick_idling();
    case ($urandom_range(2, 0))
      0: begin send_idle_pct = 0; recv_idle_pct = 0; end
      1: begin send_idle_pct = 10; recv_idle_pct = 10; end
      default: begin send_idle_pct = 30; recv_idle_pct = 30; end
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(200, 200, 50);
    add_pixel(50, 200, 200);
    add_pixel(200, 50, 200);
    add_pixel(255, 0, 1);
    add_pixel(200, 100, 101);
    add_pixel(200, 120, 90);
    add_pixel(180, 110, 80);
    add_pixel(96, 41, 21);
    add_pixel(95, 40, 20);
    add_pixel(240, 225, 190);
    add_pixel(221, 211, 171);
    add_pixel(230, 230, 200);
    add_pixel(160, 100, 95);
    add_pixel(170, 90, 60);
    add_pixel(250, 180, 150);
    drain();

    pick_idling();
    set_limits(HUE_MAX, 0);
    run_random(50);
    pick_idling();
    set_limits(0, HUE_MAX);
    run_random(50);
    pick_idling();
    set_limits(0, 0);
    run_random(45);
    pick_idling();
    set_limits(HUE_MAX, HUE_MAX);
    run_random(45);
    pick_idling();
    set_limits(int'(HUE_BELOW_RST), int'(HUE_ABOVE_RST));
    run_random(50);
    pick_idling();
    set_limits($urandom_range(HUE_MAX, 0), $urandom_range(HUE_MAX, 0));
    run_random(45);

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits($urandom_range(3000, 1000), $urandom_range(22000, 19000));
    hold_left <= 80;
    run_random(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits($urandom_range(HUE_MAX, 0), $urandom_range(HUE_MAX, 0));
    run_random(50);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/spc_pkg.sv
src/spc_color.sv
src/spc_chroma.sv
src/spc_line.sv
src/spc_div.sv
src/skin_pixel_classifier_top.sv
tb/tb_skin_pixel_classifier_top.sv
